### hw/rtl/glr_pkg.sv
// Shared constants for the grid layer rotation block: field widths,
// register indexes, geometry widths and default sizes.
// No dependencies.
`default_nettype none

package glr_pkg;

   // Field widths of the request, response and register port.
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int VALUE_W   = 16;
   localparam int DIM_W     = 7;
   localparam int SHIFT_W   = 30;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 30;

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT = 2'd2;

   // Request opcodes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Geometry arithmetic width. Dimensions go up to 127, so a ring is at most
   // 504 cells long and a position plus a remainder stays below 2048.
   localparam int GEO_W = 11;

   // Iteration counter width of the remainder unit.
   localparam int CNT_W = $clog2(SHIFT_W);

   // Default store sizes.
   localparam int DEF_MAX_ROWS   = 64;
   localparam int DEF_MAX_COLS   = 64;
   localparam int DEF_DATA_WIDTH = 16;

endpackage

`default_nettype wire

### hw/rtl/glr_grid_mem.sv
// Single-port synchronous grid store with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module glr_grid_mem #(
   parameter int DEPTH      = 4096,
   parameter int ADDR_W     = 12,
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   output      logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/glr_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle.
// Depends on glr_pkg for widths.
`default_nettype none

module glr_mod_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [glr_pkg::SHIFT_W-1:0] dividend,
   input  wire logic [glr_pkg::GEO_W-1:0]   divisor,
   output      logic                        done,
   output      logic [glr_pkg::GEO_W-1:0]   remainder
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [glr_pkg::CNT_W-1:0]   cnt_ff;
   logic [glr_pkg::SHIFT_W-1:0] num_ff;
   logic [glr_pkg::GEO_W-1:0]   rem_ff;
   logic [glr_pkg::GEO_W-1:0]   div_ff;
   logic [glr_pkg::GEO_W:0]     trial;
   logic [glr_pkg::GEO_W-1:0]   rem_in;

   // The partial remainder always stays below the divisor, so the
   // difference fits back into GEO_W bits.
   always_comb begin
      trial = {rem_ff, num_ff[glr_pkg::SHIFT_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = glr_pkg::GEO_W'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[glr_pkg::GEO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= dividend;
            rem_ff  <= '0;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            num_ff <= num_ff << 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == glr_pkg::CNT_W'(glr_pkg::SHIFT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### hw/rtl/grid_layer_rotation_core.sv
// Grid layer rotation: a write word goes into the store as it is accepted, and the next word
// can follow on the next cycle. A read word on a ring passes the states GEOM, POS, DIV (which
// waits on the remainder unit), FOLD, MAP, READ and LOAD. A read off every ring goes from GEOM
// straight to READ and LOAD. One word is worked at a time: after a read the next word is taken
// only back in idle, and a waiting response can hold the core in its load state before that.
// Synchronous active-high reset clears control state and sets rows=1, cols=1, shift=0;
// the grid store itself is not cleared and holds garbage until written.
`default_nettype none

module grid_layer_rotation_core #(
   parameter int MAX_ROWS   = glr_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = glr_pkg::DEF_MAX_COLS,
   parameter int DATA_WIDTH = glr_pkg::DEF_DATA_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel.
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [glr_pkg::ROW_W-1:0]     req_row,
   input  wire logic [glr_pkg::COL_W-1:0]     req_col,
   input  wire logic [glr_pkg::VALUE_W-1:0]   req_value,
   // Response channel.
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [glr_pkg::VALUE_W-1:0]   rsp_cell_value,
   // Register write port.
   input  wire logic                          csr_we,
   input  wire logic [glr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [glr_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RA_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CA_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int GW     = glr_pkg::GEO_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_GEOM, ST_POS, ST_DIV, ST_FOLD, ST_MAP, ST_READ, ST_LOAD
   } state_type;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [glr_pkg::DIM_W-1:0]   rows_ff;
   logic [glr_pkg::DIM_W-1:0]   cols_ff;
   logic [glr_pkg::SHIFT_W-1:0] shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= glr_pkg::DIM_W'(1);
         cols_ff  <= glr_pkg::DIM_W'(1);
         shift_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            glr_pkg::CSR_ROWS:  rows_ff  <= csr_wdata[glr_pkg::DIM_W-1:0];
            glr_pkg::CSR_COLS:  cols_ff  <= csr_wdata[glr_pkg::DIM_W-1:0];
            glr_pkg::CSR_SHIFT: shift_ff <= csr_wdata[glr_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer registers.
   // ---------------------------------------------------------------------
   state_type                   state_ff;
   logic [GW-1:0]               row_ff, col_ff;
   logic [GW-1:0]               lay_ff, bot_ff, right_ff, h_ff, w_ff, len_ff;
   logic [GW-1:0]               p_ff, q_ff;
   logic [ADDR_W-1:0]           addr_ff;
   logic                        oob_ff;
   logic                        rsp_valid_ff;
   logic [glr_pkg::VALUE_W-1:0] rsp_value_ff;

   // ---------------------------------------------------------------------
   // Store and remainder unit.
   // ---------------------------------------------------------------------
   logic                  mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]     mem_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;
   logic                  div_start, div_done;
   logic [GW-1:0]         div_rem;

   // Requests beyond the store never reach it: a write there is dropped.
   logic [GW-1:0] req_row_x, req_col_x;
   logic          req_in_store, req_take;
   logic [ADDR_W-1:0] req_addr;

   assign req_row_x    = GW'(req_row);
   assign req_col_x    = GW'(req_col);
   assign req_in_store = (req_row_x < GW'(MAX_ROWS)) && (req_col_x < GW'(MAX_COLS));
   assign req_take     = req_valid && (state_ff == ST_IDLE);
   assign req_addr     = ADDR_W'(req_row_x[RA_W-1:0]) * ADDR_W'(MAX_COLS)
                         + ADDR_W'(req_col_x[CA_W-1:0]);

   assign mem_wr_en = req_take && (req_opcode == glr_pkg::OP_WRITE) && req_in_store;
   assign mem_rd_en = (state_ff == ST_READ);
   assign mem_addr  = mem_rd_en ? addr_ff : req_addr;
   assign div_start = (state_ff == ST_POS);

   glr_grid_mem #(
      .DEPTH      (DEPTH),
      .ADDR_W     (ADDR_W),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_grid_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (DATA_WIDTH'(req_value)),
      .rd_data (mem_rd_data)
   );

   glr_mod_unit u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (shift_ff),
      .divisor   (len_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // ---------------------------------------------------------------------
   // Layer geometry of the captured cell. Sizes of zero count as one and
   // sizes above the store are cut to the store.
   // ---------------------------------------------------------------------
   logic [GW-1:0] nr, nc, min_dim, lay, bot, right, h, w;
   logic          in_grid, on_ring;
   logic [GW-1:0] d_top, d_bot, d_left, d_right, m0, m1;

   always_comb begin
      if (rows_ff == '0) begin
         nr = GW'(1);
      end else if (GW'(rows_ff) > GW'(MAX_ROWS)) begin
         nr = GW'(MAX_ROWS);
      end else begin
         nr = GW'(rows_ff);
      end
      if (cols_ff == '0) begin
         nc = GW'(1);
      end else if (GW'(cols_ff) > GW'(MAX_COLS)) begin
         nc = GW'(MAX_COLS);
      end else begin
         nc = GW'(cols_ff);
      end
      in_grid = (row_ff < nr) && (col_ff < nc);
      min_dim = (nr < nc) ? nr : nc;
      d_top   = row_ff;
      d_left  = col_ff;
      d_bot   = nr - 1'b1 - row_ff;
      d_right = nc - 1'b1 - col_ff;
      m0      = (d_top < d_left) ? d_top : d_left;
      m1      = (d_bot < d_right) ? d_bot : d_right;
      lay     = (m0 < m1) ? m0 : m1;
      on_ring = in_grid && (lay < (min_dim >> 1));
      bot     = nr - 1'b1 - lay;
      right   = nc - 1'b1 - lay;
      h       = bot - lay + 1'b1;
      w       = right - lay + 1'b1;
   end

   // Position of the cell along its ring: top row, right column, bottom row,
   // then left column upward.
   logic [GW-1:0] pos;

   always_comb begin
      if (row_ff == lay_ff) begin
         pos = col_ff - lay_ff;
      end else if (col_ff == right_ff) begin
         pos = (w_ff - 1'b1) + (row_ff - lay_ff);
      end else if (row_ff == bot_ff) begin
         pos = w_ff + (h_ff - 2'd2) + (right_ff - col_ff);
      end else begin
         pos = (w_ff << 1) + (h_ff - 2'd2) + (bot_ff - 1'b1 - row_ff);
      end
   end

   // Fold the position plus the reduced shift back into one ring length.
   logic [GW-1:0] sum, q_next;

   assign sum    = p_ff + div_rem;
   assign q_next = (sum >= len_ff) ? (sum - len_ff) : sum;

   // Turn the rotated ring position back into a cell. The side is chosen by
   // comparing against the running side boundaries in parallel.
   logic [GW-1:0] b1, b2, b3, t_row, t_col;
   logic [ADDR_W-1:0] t_addr;

   always_comb begin
      b1 = w_ff;
      b2 = w_ff + h_ff - 2'd2;
      b3 = b2 + w_ff;
      if (q_ff < b1) begin
         t_row = lay_ff;
         t_col = lay_ff + q_ff;
      end else if (q_ff < b2) begin
         t_row = lay_ff + 1'b1 + (q_ff - b1);
         t_col = right_ff;
      end else if (q_ff < b3) begin
         t_row = bot_ff;
         t_col = right_ff - (q_ff - b2);
      end else begin
         t_row = bot_ff - 1'b1 - (q_ff - b3);
         t_col = lay_ff;
      end
      t_addr = ADDR_W'(t_row[RA_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(t_col[CA_W-1:0]);
   end

   logic [ADDR_W-1:0] own_addr;
   logic              own_in_store;

   assign own_in_store = (row_ff < GW'(MAX_ROWS)) && (col_ff < GW'(MAX_COLS));
   assign own_addr     = ADDR_W'(row_ff[RA_W-1:0]) * ADDR_W'(MAX_COLS)
                         + ADDR_W'(col_ff[CA_W-1:0]);

   // ---------------------------------------------------------------------
   // Sequencer and response register. The response register lets the core
   // go back to idle while a finished word still waits on the response side;
   // a following read then holds in the load state until the register frees.
   // ---------------------------------------------------------------------
   logic rsp_fill;

   assign rsp_fill = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_fill) begin
            rsp_valid_ff <= 1'b1;
            rsp_value_ff <= oob_ff ? '0 : glr_pkg::VALUE_W'(mem_rd_data);
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && (req_opcode == glr_pkg::OP_READ)) begin
                  row_ff   <= req_row_x;
                  col_ff   <= req_col_x;
                  state_ff <= ST_GEOM;
               end
            end
            ST_GEOM: begin
               lay_ff   <= lay;
               bot_ff   <= bot;
               right_ff <= right;
               h_ff     <= h;
               w_ff     <= w;
               len_ff   <= ((w + h) << 1) - 3'd4;
               if (on_ring) begin
                  oob_ff   <= 1'b0;
                  state_ff <= ST_POS;
               end else begin
                  // Off every ring: the cell reads back as stored, or as zero outside the store.
                  oob_ff   <= !own_in_store;
                  addr_ff  <= own_addr;
                  state_ff <= ST_READ;
               end
            end
            ST_POS: begin
               p_ff     <= pos;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_FOLD;
               end
            end
            ST_FOLD: begin
               q_ff     <= q_next;
               state_ff <= ST_MAP;
            end
            ST_MAP: begin
               addr_ff  <= t_addr;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               if (rsp_fill) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;

endmodule

`default_nettype wire
